[hw/rtl/rts_pkg.sv]
// ----------------------------------------------------------------------------
// Render tile scheduler package
// Shared types and constants for the tile scheduler.
// ----------------------------------------------------------------------------
package rts_pkg;

  localparam int unsigned XY_W       = 13;
  localparam int unsigned TILE_IDX_W = 10;
  localparam int unsigned TSIZE_W    = 7;
  localparam int unsigned PASS_W     = 16;
  localparam int unsigned FULL_W     = 2 * TSIZE_W;
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSES       = 2'd3;

  localparam logic [XY_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [XY_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [TSIZE_W-1:0] RST_TILE_SIZE    = 7'd16;
  localparam logic [PASS_W-1:0]  RST_PASSES       = 16'd1;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_GEO_X,
    ST_GEO_Y,
    ST_GEO_MUL,
    ST_GEO_CHK,
    ST_GEO_T,
    ST_GEO_POS,
    ST_EXEC,
    ST_STEP,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [XY_W-1:0]       x_min;
    logic [XY_W-1:0]       y_min;
    logic [XY_W-1:0]       x_max;
    logic [XY_W-1:0]       y_max;
    logic [TILE_IDX_W-1:0] tile_index;
  } rect_t;

endpackage

[hw/rtl/render_tile_scheduler.sv]
// ----------------------------------------------------------------------------
// Render tile scheduler
// Hands out clamped tile rectangles round-robin and tracks finished tiles.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: command; tdata: finished_count
// m_axis    out  tdata: x_min, y_min, x_max, y_max, tile_index, done_res
// cfg       in   cfg_idx_i selects register, cfg_data_i holds value
//
// Advance without a tile move, report and unknown commands pass through EXEC and EMIT.
// A tile move adds STEP and CMP per tile read from the finished-count memory.
// After a configuration write the next command first rebuilds the tile grid
// with two 16-step divisions, plus a third for the tile position when the
// current tile falls inside the new grid; otherwise it restarts at tile 0.
// Reset and clear sweep the finished-count memory, clearing every entry.
// A result waits in the output register; a new command is taken meanwhile.
// ----------------------------------------------------------------------------
module render_tile_scheduler #(
  parameter int unsigned MAX_TILES     = 1024,
  parameter int unsigned MAX_TILE_SIZE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rts_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // finished_count
  input  logic [rts_pkg::CMD_W-1:0]         s_axis_tuser,  // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // x_min, y_min, x_max, y_max, tile_index, done_res
  output logic [rts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [rts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rts_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TILES + 1);
  localparam int unsigned XY_W  = rts_pkg::XY_W;
  localparam int unsigned TS_W  = rts_pkg::TSIZE_W;
  localparam int unsigned DW    = rts_pkg::DIV_W;
  localparam int unsigned FW    = rts_pkg::FULL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TILES - 1);

  // configuration
  logic [XY_W-1:0]             width_q, height_q;
  logic [TS_W-1:0]             tsize_q;
  logic [rts_pkg::PASS_W-1:0]  passes_q;

  // control state
  rts_pkg::state_e             state_q, state_d;
  logic [IDX_W-1:0]            cur_q, cur_d;
  logic [rts_pkg::PASS_W-1:0]  pass_q, pass_d;
  logic                        done_q, done_d;
  logic                        dirty_q, dirty_d;
  logic [IDX_W-1:0]            sweep_q, sweep_d;
  logic                        sweep_cmd_q, sweep_cmd_d;
  logic [XY_W-1:0]             x0_q, x0_d, y0_q, y0_d;
  logic [CNT_W-1:0]            scan_q, scan_d;
  logic                        m_valid_q, m_valid_d;

  // payload
  logic [rts_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [XY_W-1:0]             fin_q, fin_d;
  logic [XY_W-1:0]             weff_q, weff_d, heff_q, heff_d;
  logic [TS_W-1:0]             teff_q, teff_d;
  logic [DW-1:0]               bx_q, bx_d, by_q, by_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [FW-1:0]               full_q, full_d;
  rts_pkg::rect_t              res_q, res_d;
  logic [rts_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  // divider
  logic [DW-1:0]               div_rem_q, div_rem_d, div_quo_q, div_quo_d;
  logic [DW-1:0]               div_den_q, div_den_d;
  logic [rts_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [DW:0]                 div_sh;
  logic                        div_ge;
  logic [DW-1:0]               div_rem_n, div_quo_n;
  logic                        div_last;

  // memory
  logic [XY_W-1:0]             mem [MAX_TILES];
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic [XY_W-1:0]             mem_wd;
  logic [XY_W-1:0]             mem_rd_q;

  // combinational helpers
  logic                        s_acc;
  logic [XY_W-1:0]             weff_c, heff_c;
  logic [TS_W-1:0]             teff_c;
  rts_pkg::rect_t              rect_c;
  logic [XY_W:0]               x_sum, y_sum;
  logic [XY_W-1:0]             sat_c;
  logic [rts_pkg::PASS_W-1:0]  pass_inc;
  logic                        tile_wrap;
  logic [2*DW-1:0]             grid_prod;
  logic [DW+TS_W-1:0]          pos_x, pos_y;

  assign s_axis_tready = (state_q == rts_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign weff_c = (width_q == '0) ? XY_W'(1) : width_q;
  assign heff_c = (height_q == '0) ? XY_W'(1) : height_q;
  assign teff_c = (tsize_q == '0) ? TS_W'(1) :
                  ((9'(tsize_q) > 9'(MAX_TILE_SIZE)) ? TS_W'(MAX_TILE_SIZE) : tsize_q);

  assign x_sum = {1'b0, x0_q} + (XY_W + 1)'(teff_q);
  assign y_sum = {1'b0, y0_q} + (XY_W + 1)'(teff_q);

  always_comb begin
    rect_c.x_min      = x0_q;
    rect_c.y_min      = y0_q;
    rect_c.x_max      = (x_sum > {1'b0, weff_q}) ? weff_q : x_sum[XY_W-1:0];
    rect_c.y_max      = (y_sum > {1'b0, heff_q}) ? heff_q : y_sum[XY_W-1:0];
    rect_c.tile_index = rts_pkg::TILE_IDX_W'(cur_q);
  end

  assign sat_c     = ((FW)'(fin_q) > full_q) ? XY_W'(full_q) : fin_q;
  assign pass_inc  = pass_q + rts_pkg::PASS_W'(1);
  assign tile_wrap = ((CNT_W'(cur_q) + CNT_W'(1)) == count_q);
  assign grid_prod = bx_q * by_q;
  assign pos_x     = (DW + TS_W)'(div_rem_q) * (DW + TS_W)'(teff_q);
  assign pos_y     = (DW + TS_W)'(div_quo_q) * (DW + TS_W)'(teff_q);

  // restoring divider step
  assign div_sh    = {div_rem_q, div_quo_q[DW-1]};
  assign div_ge    = (div_sh >= {1'b0, div_den_q});
  assign div_rem_n = div_ge ? DW'(div_sh - {1'b0, div_den_q}) : div_sh[DW-1:0];
  assign div_quo_n = {div_quo_q[DW-2:0], div_ge};
  assign div_last  = (div_cnt_q == rts_pkg::DIV_CNT_W'(DW - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rts_pkg::ST_SWEEP: begin
        if (sweep_q == LAST_IDX) begin
          state_d = sweep_cmd_q ? rts_pkg::ST_EMIT : rts_pkg::ST_IDLE;
        end
      end
      rts_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_d = dirty_q ? rts_pkg::ST_GEO_X : rts_pkg::ST_EXEC;
        end
      end
      rts_pkg::ST_GEO_X: begin
        if (div_last) state_d = rts_pkg::ST_GEO_Y;
      end
      rts_pkg::ST_GEO_Y: begin
        if (div_last) state_d = rts_pkg::ST_GEO_MUL;
      end
      rts_pkg::ST_GEO_MUL: state_d = rts_pkg::ST_GEO_CHK;
      rts_pkg::ST_GEO_CHK: begin
        state_d = (CNT_W'(cur_q) >= count_q) ? rts_pkg::ST_EXEC : rts_pkg::ST_GEO_T;
      end
      rts_pkg::ST_GEO_T: begin
        if (div_last) state_d = rts_pkg::ST_GEO_POS;
      end
      rts_pkg::ST_GEO_POS: state_d = rts_pkg::ST_EXEC;
      rts_pkg::ST_EXEC: begin
        case (cmd_q)
          rts_pkg::CMD_ADVANCE: begin
            if (done_q || (pass_inc < passes_q)) state_d = rts_pkg::ST_EMIT;
            else state_d = rts_pkg::ST_STEP;
          end
          rts_pkg::CMD_CLEAR: state_d = rts_pkg::ST_SWEEP;
          default:            state_d = rts_pkg::ST_EMIT;
        endcase
      end
      rts_pkg::ST_STEP: state_d = rts_pkg::ST_CMP;
      rts_pkg::ST_CMP: begin
        if ((FW)'(mem_rd_q) < full_q) state_d = rts_pkg::ST_EMIT;
        else if ((scan_q + CNT_W'(1)) == count_q) state_d = rts_pkg::ST_EMIT;
        else state_d = rts_pkg::ST_STEP;
      end
      rts_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) state_d = rts_pkg::ST_IDLE;
      end
      default: state_d = rts_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_d       = cur_q;
    pass_d      = pass_q;
    done_d      = done_q;
    dirty_d     = dirty_q || cfg_we_i;
    sweep_d     = sweep_q;
    sweep_cmd_d = sweep_cmd_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    scan_d      = scan_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    cmd_d       = cmd_q;
    fin_d       = fin_q;
    weff_d      = weff_q;
    heff_d      = heff_q;
    teff_d      = teff_q;
    bx_d        = bx_q;
    by_d        = by_q;
    count_d     = count_q;
    full_d      = full_q;
    res_d       = res_q;
    m_data_d    = m_data_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_den_d   = div_den_q;
    div_cnt_d   = div_cnt_q;
    mem_we      = 1'b0;
    mem_wa      = cur_q;
    mem_wd      = sat_c;

    unique case (state_q) inside
      rts_pkg::ST_SWEEP: begin
        mem_we  = 1'b1;
        mem_wa  = sweep_q;
        mem_wd  = '0;
        sweep_d = sweep_q + IDX_W'(1);
        if (sweep_q == LAST_IDX) res_d = rect_c;
      end
      rts_pkg::ST_IDLE: begin
        if (s_acc) begin
          cmd_d     = s_axis_tuser;
          fin_d     = s_axis_tdata[XY_W-1:0];
          weff_d    = weff_c;
          heff_d    = heff_c;
          teff_d    = teff_c;
          div_quo_d = DW'(weff_c) + DW'(teff_c) - DW'(1);
          div_rem_d = '0;
          div_den_d = DW'(teff_c);
          div_cnt_d = '0;
        end
      end
      rts_pkg::ST_GEO_X, rts_pkg::ST_GEO_Y, rts_pkg::ST_GEO_T: begin
        div_rem_d = div_rem_n;
        div_quo_d = div_quo_n;
        div_cnt_d = div_cnt_q + rts_pkg::DIV_CNT_W'(1);
        if (div_last && (state_q == rts_pkg::ST_GEO_X)) begin
          bx_d      = div_quo_n;
          div_quo_d = DW'(heff_q) + DW'(teff_q) - DW'(1);
          div_rem_d = '0;
          div_cnt_d = '0;
        end
        if (div_last && (state_q == rts_pkg::ST_GEO_Y)) begin
          by_d = div_quo_n;
        end
      end
      rts_pkg::ST_GEO_MUL: begin
        count_d = (grid_prod > (2*DW)'(MAX_TILES)) ? CNT_W'(MAX_TILES)
                                                    : CNT_W'(grid_prod);
        full_d  = FW'(teff_q) * FW'(teff_q);
      end
      rts_pkg::ST_GEO_CHK: begin
        if (CNT_W'(cur_q) >= count_q) begin
          cur_d   = '0;
          x0_d    = '0;
          y0_d    = '0;
          dirty_d = cfg_we_i;
        end else begin
          div_quo_d = DW'(cur_q);
          div_rem_d = '0;
          div_den_d = bx_q;
          div_cnt_d = '0;
        end
      end
      rts_pkg::ST_GEO_POS: begin
        x0_d    = pos_x[XY_W-1:0];
        y0_d    = pos_y[XY_W-1:0];
        dirty_d = cfg_we_i;
      end
      rts_pkg::ST_EXEC: begin
        res_d = rect_c;
        case (cmd_q)
          rts_pkg::CMD_ADVANCE: begin
            if (!done_q) begin
              if (pass_inc < passes_q) begin
                pass_d = pass_inc;
              end else begin
                pass_d = '0;
                scan_d = '0;
              end
            end
          end
          rts_pkg::CMD_REPORT: begin
            mem_we = 1'b1;
          end
          rts_pkg::CMD_CLEAR: begin
            cur_d       = '0;
            pass_d      = '0;
            done_d      = 1'b0;
            x0_d        = '0;
            y0_d        = '0;
            sweep_d     = '0;
            sweep_cmd_d = 1'b1;
          end
          default: ;
        endcase
      end
      rts_pkg::ST_STEP: begin
        if (tile_wrap) begin
          cur_d = '0;
          x0_d  = '0;
          y0_d  = '0;
        end else begin
          cur_d = cur_q + IDX_W'(1);
          if (x_sum >= {1'b0, weff_q}) begin
            x0_d = '0;
            y0_d = y_sum[XY_W-1:0];
          end else begin
            x0_d = x_sum[XY_W-1:0];
          end
        end
      end
      rts_pkg::ST_CMP: begin
        if ((FW)'(mem_rd_q) >= full_q) begin
          scan_d = scan_q + CNT_W'(1);
          if ((scan_q + CNT_W'(1)) == count_q) done_d = 1'b1;
        end
      end
      rts_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, done_q, res_q.tile_index, res_q.y_max, res_q.x_max,
                       res_q.y_min, res_q.x_min};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= rts_pkg::RST_IMAGE_WIDTH;
      height_q    <= rts_pkg::RST_IMAGE_HEIGHT;
      tsize_q     <= rts_pkg::RST_TILE_SIZE;
      passes_q    <= rts_pkg::RST_PASSES;
      state_q     <= rts_pkg::ST_SWEEP;
      cur_q       <= '0;
      pass_q      <= '0;
      done_q      <= 1'b0;
      dirty_q     <= 1'b1;
      sweep_q     <= '0;
      sweep_cmd_q <= 1'b0;
      x0_q        <= '0;
      y0_q        <= '0;
      scan_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rts_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[XY_W-1:0];
          rts_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[XY_W-1:0];
          rts_pkg::CFG_TILE_SIZE:    tsize_q  <= cfg_data_i[TS_W-1:0];
          rts_pkg::CFG_PASSES:       passes_q <= cfg_data_i;
          default: ;
        endcase
      end
      state_q     <= state_d;
      cur_q       <= cur_d;
      pass_q      <= pass_d;
      done_q      <= done_d;
      dirty_q     <= dirty_d;
      sweep_q     <= sweep_d;
      sweep_cmd_q <= sweep_cmd_d;
      x0_q        <= x0_d;
      y0_q        <= y0_d;
      scan_q      <= scan_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    fin_q     <= fin_d;
    weff_q    <= weff_d;
    heff_q    <= heff_d;
    teff_q    <= teff_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    count_q   <= count_d;
    full_q    <= full_d;
    res_q     <= res_d;
    m_data_q  <= m_data_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    div_cnt_q <= div_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[cur_d];
  end

  a_tile_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rts_pkg::ST_EXEC) |-> (CNT_W'(cur_q) < count_q))
    else $error("current tile outside the grid");

  a_col_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rts_pkg::ST_EXEC) |-> (x0_q < weff_q))
    else $error("tile column beyond image width");

  a_report_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == rts_pkg::ST_EXEC)) |-> ((FW)'(mem_wd) <= full_q))
    else $error("stored finished count above tile area");

  a_done_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) == rts_pkg::ST_CMP))
    else $error("done raised outside the tile scan");

endmodule
